// ===== src/ddrpd_pkg.sv =====
// shared types, register indexes, operation codes and constants of the drive controller
`default_nettype none

package ddrpd_pkg;

  // field and datapath widths
  localparam int CFG_W   = 16;
  localparam int ERR_W   = 32;
  localparam int DIF_W   = ERR_W + 1;
  localparam int SUM_W   = 50;
  localparam int DRV_W   = 9;
  localparam int DUTY_W  = 8;
  localparam int IDX_W   = 3;
  localparam int DRV_MAX = 255;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_ACCEL_FWD = 3'd0;
  localparam logic [IDX_W-1:0] REG_DECEL_FWD = 3'd1;
  localparam logic [IDX_W-1:0] REG_ACCEL_ROT = 3'd2;
  localparam logic [IDX_W-1:0] REG_DECEL_ROT = 3'd3;
  localparam logic [IDX_W-1:0] REG_KP_FWD    = 3'd4;
  localparam logic [IDX_W-1:0] REG_KD_FWD    = 3'd5;
  localparam logic [IDX_W-1:0] REG_KP_ROT    = 3'd6;
  localparam logic [IDX_W-1:0] REG_KD_ROT    = 3'd7;

  // register reset values
  localparam logic [CFG_W-1:0]        RST_ACCEL_FWD = 16'd184;
  localparam logic [CFG_W-1:0]        RST_DECEL_FWD = 16'd403;
  localparam logic [CFG_W-1:0]        RST_ACCEL_ROT = 16'd384;
  localparam logic [CFG_W-1:0]        RST_DECEL_ROT = 16'd384;
  localparam logic signed [CFG_W-1:0] RST_KP_FWD    = 16'sd102;
  localparam logic signed [CFG_W-1:0] RST_KD_FWD    = 16'sd26;
  localparam logic signed [CFG_W-1:0] RST_KP_ROT    = 16'sd256;
  localparam logic signed [CFG_W-1:0] RST_KD_ROT    = 16'sd512;

  // datapath operation codes
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE  = 4'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 4'd1;
  localparam logic [OP_W-1:0] OP_RAMP  = 4'd2;
  localparam logic [OP_W-1:0] OP_NUM   = 4'd3;
  localparam logic [OP_W-1:0] OP_RCP   = 4'd4;
  localparam logic [OP_W-1:0] OP_QMUL  = 4'd5;
  localparam logic [OP_W-1:0] OP_FBK   = 4'd6;
  localparam logic [OP_W-1:0] OP_ERR   = 4'd7;
  localparam logic [OP_W-1:0] OP_MPF   = 4'd8;
  localparam logic [OP_W-1:0] OP_MDF   = 4'd9;
  localparam logic [OP_W-1:0] OP_MPR   = 4'd10;
  localparam logic [OP_W-1:0] OP_MDR   = 4'd11;
  localparam logic [OP_W-1:0] OP_SUMR  = 4'd12;
  localparam logic [OP_W-1:0] OP_TRUNC = 4'd13;
  localparam logic [OP_W-1:0] OP_EMIT  = 4'd14;

  // configuration register file contents
  typedef struct packed {
    logic [CFG_W-1:0]        accel_step_fwd;
    logic [CFG_W-1:0]        decel_step_fwd;
    logic [CFG_W-1:0]        accel_step_rot;
    logic [CFG_W-1:0]        decel_step_rot;
    logic signed [CFG_W-1:0] prop_gain_fwd;
    logic signed [CFG_W-1:0] deriv_gain_fwd;
    logic signed [CFG_W-1:0] prop_gain_rot;
    logic signed [CFG_W-1:0] deriv_gain_rot;
  } cfg_t;

  // controller to datapath command
  typedef struct packed {
    logic            load;
    logic [OP_W-1:0] op;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clear;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== src/ddrpd_regs.sv =====
// configuration register file with write channel
`default_nettype none

module ddrpd_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output      logic                        cfg_ready,
  input  wire logic [ddrpd_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [ddrpd_pkg::CFG_W-1:0] cfg_data,
  output      ddrpd_pkg::cfg_t             cfg
);
  import ddrpd_pkg::*;

  // writes are always taken
  assign cfg_ready = 1'b1;

  // register write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.accel_step_fwd <= RST_ACCEL_FWD;
      cfg.decel_step_fwd <= RST_DECEL_FWD;
      cfg.accel_step_rot <= RST_ACCEL_ROT;
      cfg.decel_step_rot <= RST_DECEL_ROT;
      cfg.prop_gain_fwd  <= RST_KP_FWD;
      cfg.deriv_gain_fwd <= RST_KD_FWD;
      cfg.prop_gain_rot  <= RST_KP_ROT;
      cfg.deriv_gain_rot <= RST_KD_ROT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ACCEL_FWD: cfg.accel_step_fwd <= cfg_data;
        REG_DECEL_FWD: cfg.decel_step_fwd <= cfg_data;
        REG_ACCEL_ROT: cfg.accel_step_rot <= cfg_data;
        REG_DECEL_ROT: cfg.decel_step_rot <= cfg_data;
        REG_KP_FWD:    cfg.prop_gain_fwd  <= signed'(cfg_data);
        REG_KD_FWD:    cfg.deriv_gain_fwd <= signed'(cfg_data);
        REG_KP_ROT:    cfg.prop_gain_rot  <= signed'(cfg_data);
        REG_KD_ROT:    cfg.deriv_gain_rot <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/ddrpd_ctrl.sv =====
// sequencing state machine for one control tick
`default_nettype none

module ddrpd_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output      logic                  in_stall,
  output      logic                  out_valid,
  input  wire logic                  out_stall,
  input  wire ddrpd_pkg::dp_status_t status,
  output      ddrpd_pkg::dp_cmd_t    cmd
);
  import ddrpd_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RAMP  = 4'd1;
  localparam logic [3:0] S_NUM   = 4'd2;
  localparam logic [3:0] S_RCP   = 4'd3;
  localparam logic [3:0] S_QMUL  = 4'd4;
  localparam logic [3:0] S_FBK   = 4'd5;
  localparam logic [3:0] S_ERR   = 4'd6;
  localparam logic [3:0] S_MPF   = 4'd7;
  localparam logic [3:0] S_MDF   = 4'd8;
  localparam logic [3:0] S_MPR   = 4'd9;
  localparam logic [3:0] S_MDR   = 4'd10;
  localparam logic [3:0] S_SUMR  = 4'd11;
  localparam logic [3:0] S_TRUNC = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       emit_ok;

  // output register is free or being emptied this cycle
  assign emit_ok  = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_RAMP;
        end
      end
      S_RAMP: begin
        cmd.op     = status.clear ? OP_CLEAR : OP_RAMP;
        state_next = status.clear ? S_OUT : S_NUM;
      end
      S_NUM: begin
        cmd.op     = OP_NUM;
        state_next = S_RCP;
      end
      S_RCP: begin
        cmd.op     = OP_RCP;
        state_next = S_QMUL;
      end
      S_QMUL: begin
        cmd.op     = OP_QMUL;
        state_next = S_FBK;
      end
      S_FBK: begin
        cmd.op     = OP_FBK;
        state_next = S_ERR;
      end
      S_ERR: begin
        cmd.op     = OP_ERR;
        state_next = S_MPF;
      end
      S_MPF: begin
        cmd.op     = OP_MPF;
        state_next = S_MDF;
      end
      S_MDF: begin
        cmd.op     = OP_MDF;
        state_next = S_MPR;
      end
      S_MPR: begin
        cmd.op     = OP_MPR;
        state_next = S_MDR;
      end
      S_MDR: begin
        cmd.op     = OP_MDR;
        state_next = S_SUMR;
      end
      S_SUMR: begin
        cmd.op     = OP_SUMR;
        state_next = S_TRUNC;
      end
      S_TRUNC: begin
        cmd.op     = OP_TRUNC;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (emit_ok) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== src/ddrpd_dpath.sv =====
// ramp, feedback divide, error accumulation, shared multiplier and drive mixing
`default_nettype none

module ddrpd_dpath #(
  parameter int SENSOR_DIVISOR = 50,
  parameter int FRAC_BITS      = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire ddrpd_pkg::dp_cmd_t                  cmd,
  output      ddrpd_pkg::dp_status_t               status,
  input  wire ddrpd_pkg::cfg_t                     cfg,
  input  wire logic                                cmd_in,
  input  wire logic signed [7:0]                   left_wheel_delta,
  input  wire logic signed [7:0]                   right_wheel_delta,
  input  wire logic signed [12:0]                  wall_error,
  input  wire logic                                sensor_enable,
  input  wire logic signed [ddrpd_pkg::CFG_W-1:0]  goal_speed_fwd,
  input  wire logic signed [ddrpd_pkg::CFG_W-1:0]  goal_speed_rot,
  output      logic signed [ddrpd_pkg::DRV_W-1:0]  left_drive,
  output      logic signed [ddrpd_pkg::DRV_W-1:0]  right_drive,
  output      logic [ddrpd_pkg::DUTY_W-1:0]        left_fwd_duty,
  output      logic [ddrpd_pkg::DUTY_W-1:0]        left_rev_duty,
  output      logic [ddrpd_pkg::DUTY_W-1:0]        right_fwd_duty,
  output      logic [ddrpd_pkg::DUTY_W-1:0]        right_rev_duty,
  output      logic signed [ddrpd_pkg::CFG_W-1:0]  ramped_speed_fwd,
  output      logic signed [ddrpd_pkg::CFG_W-1:0]  ramped_speed_rot
);
  import ddrpd_pkg::*;

  // magnitude of the sensor-corrected rotational numerator
  localparam int MAG_W   = $clog2(DRV_MAX * SENSOR_DIVISOR + 4096 + 1);
  localparam int NUM_W   = MAG_W + 1;
  localparam int RCP_S   = MAG_W;
  localparam int RECIP_W = RCP_S + 1;
  localparam int MA_W    = (MAG_W + 1 > CFG_W + 1) ? MAG_W + 1 : CFG_W + 1;
  localparam int MB_W    = ERR_W + 2;
  localparam int PW      = MA_W + MB_W;
  localparam int SCALE_W = 2 * FRAC_BITS;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RCP_S) / SENSOR_DIVISOR);
  localparam logic [MAG_W-1:0]   DIV_C = MAG_W'(SENSOR_DIVISOR);
  localparam logic signed [SUM_W-1:0] BIAS = SUM_W'((64'd1 << SCALE_W) - 1);
  localparam logic signed [SUM_W:0]   SAT_HI = (SUM_W + 1)'(DRV_MAX);
  localparam logic signed [SUM_W:0]   SAT_LO = -((SUM_W + 1)'(DRV_MAX));

  // latched input word
  logic                    cmd_r;
  logic signed [7:0]       dl;
  logic signed [7:0]       dr;
  logic signed [12:0]      wall;
  logic                    sen;
  logic signed [CFG_W-1:0] goal_f;
  logic signed [CFG_W-1:0] goal_r;

  // tick state
  logic signed [CFG_W-1:0] speed_f;
  logic signed [CFG_W-1:0] speed_r;
  logic signed [ERR_W-1:0] err_f;
  logic signed [ERR_W-1:0] err_r;
  logic signed [ERR_W-1:0] prev_f;
  logic signed [ERR_W-1:0] prev_r;

  // working registers
  logic signed [PW-1:0]    prod;
  logic                    nneg;
  logic [MAG_W-1:0]        nmag;
  logic [MAG_W-1:0]        q0;
  logic signed [NUM_W-1:0] fb_rot;
  logic signed [DIF_W-1:0] dif_f;
  logic signed [DIF_W-1:0] dif_r;
  logic signed [SUM_W-1:0] acc_f;
  logic signed [SUM_W-1:0] acc_r;

  // combinational helpers
  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [8:0]       fwd_raw;
  logic signed [8:0]       rot_raw;
  logic signed [NUM_W-1:0] num;
  logic [MAG_W-1:0]        q0_w;
  logic [MAG_W-1:0]        rem;
  logic [MAG_W-1:0]        quo;
  logic signed [NUM_W-1:0] quo_s;
  logic signed [SUM_W-1:0] prod_s;
  logic signed [SUM_W:0]   mix_l;
  logic signed [SUM_W:0]   mix_r;
  logic signed [DRV_W-1:0] drv_l;
  logic signed [DRV_W-1:0] drv_r;

  // one ramp step toward the goal, landing on it on overshoot
  function automatic logic signed [CFG_W-1:0] ramp_step(
    input logic signed [CFG_W-1:0] now,
    input logic signed [CFG_W-1:0] goal,
    input logic [CFG_W-1:0]        up,
    input logic [CFG_W-1:0]        down
  );
    logic signed [CFG_W+1:0] nw;
    logic signed [CFG_W+1:0] gl;
    logic signed [CFG_W+1:0] t;
    nw = (CFG_W + 2)'(now);
    gl = (CFG_W + 2)'(goal);
    t  = nw;
    if (nw < gl) begin
      t = nw + signed'({2'b00, up});
      if (t > gl) t = gl;
    end else if (nw > gl) begin
      t = nw - signed'({2'b00, down});
      if (t < gl) t = gl;
    end
    return t[CFG_W-1:0];
  endfunction

  // divide by 2^(2*FRAC_BITS), rounding toward zero
  function automatic logic signed [SUM_W-1:0] trunc_scale(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] b;
    b = x[SUM_W-1] ? x + BIAS : x;
    return b >>> SCALE_W;
  endfunction

  // clamp to the drive range
  function automatic logic signed [DRV_W-1:0] sat_drive(input logic signed [SUM_W:0] v);
    logic signed [DRV_W-1:0] s;
    if (v > SAT_HI) s = DRV_W'(DRV_MAX);
    else if (v < SAT_LO) s = -(DRV_W'(DRV_MAX));
    else s = v[DRV_W-1:0];
    return s;
  endfunction

  assign status.clear = cmd_r;

  // encoder sums and the reciprocal-divide pieces
  assign fwd_raw = 9'(dr) + 9'(dl);
  assign rot_raw = 9'(dr) - 9'(dl);
  assign num     = signed'(prod[NUM_W-1:0]) - NUM_W'(wall);
  assign q0_w    = prod[RCP_S+MAG_W-1:RCP_S];
  assign rem     = nmag - prod[MAG_W-1:0];
  assign quo     = q0 + MAG_W'(rem >= DIV_C);
  assign quo_s   = signed'({1'b0, quo});
  assign prod_s  = signed'(prod[SUM_W-1:0]);

  // drive mix and saturation
  assign mix_l = (SUM_W + 1)'(acc_f) - (SUM_W + 1)'(acc_r);
  assign mix_r = (SUM_W + 1)'(acc_f) + (SUM_W + 1)'(acc_r);
  assign drv_l = sat_drive(mix_l);
  assign drv_r = sat_drive(mix_r);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_RAMP: begin
        mul_a = MA_W'(rot_raw);
        mul_b = MB_W'(SENSOR_DIVISOR);
      end
      OP_RCP: begin
        mul_a = MA_W'(nmag);
        mul_b = MB_W'(RECIP);
      end
      OP_QMUL: begin
        mul_a = MA_W'(q0_w);
        mul_b = MB_W'(SENSOR_DIVISOR);
      end
      OP_MPF: begin
        mul_a = MA_W'(cfg.prop_gain_fwd);
        mul_b = MB_W'(err_f);
      end
      OP_MDF: begin
        mul_a = MA_W'(cfg.deriv_gain_fwd);
        mul_b = MB_W'(dif_f);
      end
      OP_MPR: begin
        mul_a = MA_W'(cfg.prop_gain_rot);
        mul_b = MB_W'(err_r);
      end
      OP_MDR: begin
        mul_a = MA_W'(cfg.deriv_gain_rot);
        mul_b = MB_W'(dif_r);
      end
      default: ;
    endcase
  end

  // product register
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // input word capture
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_r <= 1'b0;
    end else if (cmd.load) begin
      cmd_r <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dl     <= left_wheel_delta;
      dr     <= right_wheel_delta;
      wall   <= wall_error;
      sen    <= sensor_enable;
      goal_f <= goal_speed_fwd;
      goal_r <= goal_speed_rot;
    end
  end

  // tick state: speeds, error sums and previous errors
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_f <= '0;
      speed_r <= '0;
      err_f   <= '0;
      err_r   <= '0;
      prev_f  <= '0;
      prev_r  <= '0;
    end else begin
      case (cmd.op)
        OP_CLEAR: begin
          speed_f <= '0;
          speed_r <= '0;
          err_f   <= '0;
          err_r   <= '0;
          prev_f  <= '0;
          prev_r  <= '0;
        end
        OP_RAMP: begin
          speed_f <= ramp_step(speed_f, goal_f, cfg.accel_step_fwd, cfg.decel_step_fwd);
          speed_r <= ramp_step(speed_r, goal_r, cfg.accel_step_rot, cfg.decel_step_rot);
        end
        OP_ERR: begin
          err_f <= err_f + ERR_W'(speed_f) - (ERR_W'(fwd_raw) <<< FRAC_BITS);
          err_r <= err_r + ERR_W'(speed_r) - (ERR_W'(fb_rot) <<< FRAC_BITS);
        end
        OP_MPF: begin
          prev_f <= err_f;
          prev_r <= err_r;
        end
        default: ;
      endcase
    end
  end

  // divide steps, differences and PD sums
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CLEAR: begin
        acc_f <= '0;
        acc_r <= '0;
      end
      OP_NUM: begin
        nneg <= num[NUM_W-1];
        nmag <= num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
      end
      OP_QMUL: q0 <= q0_w;
      OP_FBK: begin
        if (sen) begin
          fb_rot <= nneg ? -quo_s : quo_s;
        end else begin
          fb_rot <= NUM_W'(rot_raw);
        end
      end
      OP_MPF: begin
        dif_f <= DIF_W'(err_f) - DIF_W'(prev_f);
        dif_r <= DIF_W'(err_r) - DIF_W'(prev_r);
      end
      OP_MDF:  acc_f <= prod_s;
      OP_MPR:  acc_f <= acc_f - prod_s;
      OP_MDR:  acc_r <= prod_s;
      OP_SUMR: acc_r <= acc_r + prod_s;
      OP_TRUNC: begin
        acc_f <= trunc_scale(acc_f);
        acc_r <= trunc_scale(acc_r);
      end
      default: ;
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      left_drive       <= drv_l;
      right_drive      <= drv_r;
      left_fwd_duty    <= drv_l[DRV_W-1] ? '0 : drv_l[DUTY_W-1:0];
      left_rev_duty    <= drv_l[DRV_W-1] ? DUTY_W'(-drv_l) : '0;
      right_fwd_duty   <= drv_r[DRV_W-1] ? '0 : drv_r[DUTY_W-1:0];
      right_rev_duty   <= drv_r[DRV_W-1] ? DUTY_W'(-drv_r) : '0;
      ramped_speed_fwd <= speed_f;
      ramped_speed_rot <= speed_r;
    end
  end

endmodule

`default_nettype wire

// ===== src/diff_drive_ramp_pd_controller.sv =====
// Differential-drive PD motor controller with forward and rotational speed ramps.
// A word is taken only while the sequencer is idle; the input stays stalled until its result
// has been emitted, and emission waits while the output register is full and stalled. A tick runs
// seven operations through the single shared multiplier; a clear skips them.
// Reset (synchronous): controller idle, output empty, registers at defaults, state zero.
`default_nettype none

module diff_drive_ramp_pd_controller #(
  parameter int SENSOR_DIVISOR = 50,
  parameter int FRAC_BITS      = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output      logic                                in_stall,
  input  wire logic                                cmd,
  input  wire logic signed [7:0]                   left_wheel_delta,
  input  wire logic signed [7:0]                   right_wheel_delta,
  input  wire logic signed [12:0]                  wall_error,
  input  wire logic                                sensor_enable,
  input  wire logic signed [ddrpd_pkg::CFG_W-1:0]  goal_speed_fwd,
  input  wire logic signed [ddrpd_pkg::CFG_W-1:0]  goal_speed_rot,
  output      logic                                out_valid,
  input  wire logic                                out_stall,
  output      logic signed [ddrpd_pkg::DRV_W-1:0]  left_drive,
  output      logic signed [ddrpd_pkg::DRV_W-1:0]  right_drive,
  output      logic [ddrpd_pkg::DUTY_W-1:0]        left_fwd_duty,
  output      logic [ddrpd_pkg::DUTY_W-1:0]        left_rev_duty,
  output      logic [ddrpd_pkg::DUTY_W-1:0]        right_fwd_duty,
  output      logic [ddrpd_pkg::DUTY_W-1:0]        right_rev_duty,
  output      logic signed [ddrpd_pkg::CFG_W-1:0]  ramped_speed_fwd,
  output      logic signed [ddrpd_pkg::CFG_W-1:0]  ramped_speed_rot,
  input  wire logic                                cfg_valid,
  output      logic                                cfg_ready,
  input  wire logic [ddrpd_pkg::IDX_W-1:0]         cfg_index,
  input  wire logic [ddrpd_pkg::CFG_W-1:0]         cfg_data
);
  import ddrpd_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // configuration registers
  ddrpd_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer
  ddrpd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (dp_status),
    .cmd       (dp_cmd)
  );

  // arithmetic
  ddrpd_dpath #(
    .SENSOR_DIVISOR (SENSOR_DIVISOR),
    .FRAC_BITS      (FRAC_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (dp_cmd),
    .status            (dp_status),
    .cfg               (cfg),
    .cmd_in            (cmd),
    .left_wheel_delta  (left_wheel_delta),
    .right_wheel_delta (right_wheel_delta),
    .wall_error        (wall_error),
    .sensor_enable     (sensor_enable),
    .goal_speed_fwd    (goal_speed_fwd),
    .goal_speed_rot    (goal_speed_rot),
    .left_drive        (left_drive),
    .right_drive       (right_drive),
    .left_fwd_duty     (left_fwd_duty),
    .left_rev_duty     (left_rev_duty),
    .right_fwd_duty    (right_fwd_duty),
    .right_rev_duty    (right_rev_duty),
    .ramped_speed_fwd  (ramped_speed_fwd),
    .ramped_speed_rot  (ramped_speed_rot)
  );

  // a taken word starts the sequence, so the input closes right after
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after accepting a word");

  // only one pin of each side carries duty
  a_one_pin: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((left_fwd_duty == '0) || (left_rev_duty == '0)) &&
                  ((right_fwd_duty == '0) || (right_rev_duty == '0)))
    else $error("forward and reverse duty both active");

  // a non-negative drive goes out on the forward pin unchanged
  a_fwd_duty_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && !left_drive[DRV_W-1] |->
      (left_rev_duty == '0) && (left_fwd_duty == left_drive[DUTY_W-1:0]))
    else $error("left duty split does not match drive");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// self-checking testbench for the differential-drive ramp pd controller
module tb;
  import ddrpd_pkg::*;

  localparam int     SENS_DIV       = 50;
  localparam int     FRAC           = 8;
  localparam longint ONE_Q          = longint'(1) << FRAC;
  localparam longint SCALE_Q        = longint'(1) << (2 * FRAC);
  localparam int     WATCHDOG_LIMIT = 2000;
  localparam int     HOLD_CYCLES    = 200;
  localparam int     END_SETTLE     = 30;
  localparam int     SOAK_TICKS     = 40;

  typedef enum logic {CMD_TICK = 1'b0, CMD_CLEAR = 1'b1} tick_cmd_e;

  // one input word as it appears on the ports
  typedef struct packed {
    logic               op;
    logic signed [7:0]  left_delta;
    logic signed [7:0]  right_delta;
    logic signed [12:0] wall_err;
    logic               sensor_en;
    logic signed [15:0] goal_fwd;
    logic signed [15:0] goal_rot;
  } tick_t;

  // one output word as it appears on the ports
  typedef struct packed {
    logic signed [DRV_W-1:0] left_drv;
    logic signed [DRV_W-1:0] right_drv;
    logic [DUTY_W-1:0]       left_fwd;
    logic [DUTY_W-1:0]       left_rev;
    logic [DUTY_W-1:0]       right_fwd;
    logic [DUTY_W-1:0]       right_rev;
    logic signed [CFG_W-1:0] spd_fwd;
    logic signed [CFG_W-1:0] spd_rot;
  } drive_word_t;

  // drive predictor and store of drive words still due
  class drive_scoreboard;
    cfg_t                    gains;
    logic signed [CFG_W-1:0] fwd_speed, rot_speed;
    logic [ERR_W-1:0]        fwd_err_acc, rot_err_acc, fwd_err_last, rot_err_last;
    drive_word_t             drive_words_due[$];
    int                      mismatches;

    function new();
      gains = {RST_ACCEL_FWD, RST_DECEL_FWD, RST_ACCEL_ROT, RST_DECEL_ROT,
               RST_KP_FWD, RST_KD_FWD, RST_KP_ROT, RST_KD_ROT};
      clear_state();
      mismatches = 0;
    endfunction

    function void clear_state();
      fwd_speed    = '0;
      rot_speed    = '0;
      fwd_err_acc  = '0;
      rot_err_acc  = '0;
      fwd_err_last = '0;
      rot_err_last = '0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_ACCEL_FWD: gains.accel_step_fwd = data;
        REG_DECEL_FWD: gains.decel_step_fwd = data;
        REG_ACCEL_ROT: gains.accel_step_rot = data;
        REG_DECEL_ROT: gains.decel_step_rot = data;
        REG_KP_FWD:    gains.prop_gain_fwd  = data;
        REG_KD_FWD:    gains.deriv_gain_fwd = data;
        REG_KP_ROT:    gains.prop_gain_rot  = data;
        REG_KD_ROT:    gains.deriv_gain_rot = data;
        default: ;
      endcase
    endfunction

    // one step toward the goal, landing on it when the step overshoots
    function logic signed [CFG_W-1:0] ramp_toward(logic signed [CFG_W-1:0] cur,
                                                  logic signed [CFG_W-1:0] goal,
                                                  logic [CFG_W-1:0] up,
                                                  logic [CFG_W-1:0] down);
      longint v;
      v = cur;
      if (cur < goal) begin
        v = v + longint'(up);
        if (v > goal) v = goal;
      end else if (cur > goal) begin
        v = v - longint'(down);
        if (v < goal) v = goal;
      end
      return 16'(v);
    endfunction

    function longint clamp_drive(longint v);
      if (v > DRV_MAX) return DRV_MAX;
      if (v < -DRV_MAX) return -DRV_MAX;
      return v;
    endfunction

    // work out the drive word caused by one accepted input word
    function void note_tick(tick_t t);
      drive_word_t w;
      longint dl, dr, wall, fb_fwd, fb_rot, ef, er, ef_last, er_last, pf, pr, l, r;
      w = '0;
      if (t.op == CMD_CLEAR) begin
        clear_state();
        drive_words_due.push_back(w);
        return;
      end
      dl   = t.left_delta;
      dr   = t.right_delta;
      wall = t.wall_err;

      fwd_speed = ramp_toward(fwd_speed, t.goal_fwd, gains.accel_step_fwd,
                              gains.decel_step_fwd);
      rot_speed = ramp_toward(rot_speed, t.goal_rot, gains.accel_step_rot,
                              gains.decel_step_rot);

      // encoder feedback, rotation trimmed by the wall sensor
      fb_fwd = dr + dl;
      fb_rot = dr - dl;
      if (t.sensor_en) fb_rot = (fb_rot * SENS_DIV - wall) / SENS_DIV;

      // position error sums wrap at 32 bits
      fwd_err_acc = fwd_err_acc + 32'(longint'(fwd_speed) - fb_fwd * ONE_Q);
      rot_err_acc = rot_err_acc + 32'(longint'(rot_speed) - fb_rot * ONE_Q);

      ef      = $signed(fwd_err_acc);
      er      = $signed(rot_err_acc);
      ef_last = $signed(fwd_err_last);
      er_last = $signed(rot_err_last);

      // pd terms, truncated toward zero
      pf = (longint'($signed(gains.prop_gain_fwd)) * ef -
            longint'($signed(gains.deriv_gain_fwd)) * (ef - ef_last)) / SCALE_Q;
      pr = (longint'($signed(gains.prop_gain_rot)) * er +
            longint'($signed(gains.deriv_gain_rot)) * (er - er_last)) / SCALE_Q;

      fwd_err_last = fwd_err_acc;
      rot_err_last = rot_err_acc;

      // mix, saturate and split into pin duties
      l = clamp_drive(pf - pr);
      r = clamp_drive(pf + pr);
      w.left_drv  = 9'(l);
      w.right_drv = 9'(r);
      if (l >= 0) w.left_fwd = 8'(l);
      else w.left_rev = 8'(-l);
      if (r >= 0) w.right_fwd = 8'(r);
      else w.right_rev = 8'(-r);
      w.spd_fwd = fwd_speed;
      w.spd_rot = rot_speed;
      drive_words_due.push_back(w);
    endfunction

    function void compare_field(string fname, logic signed [31:0] want,
                                logic signed [31:0] got);
      if (got !== want) begin
        $display("%0t mismatch on %s: expected %0d, actual %0d", $time, fname, want, got);
        mismatches++;
      end
    endfunction

    function void check_drive_word(drive_word_t got);
      drive_word_t want;
      if (drive_words_due.size() == 0) begin
        $display("%0t unexpected drive word: left %0d right %0d", $time,
                 got.left_drv, got.right_drv);
        mismatches++;
        return;
      end
      want = drive_words_due.pop_front();
      compare_field("left_drive", want.left_drv, got.left_drv);
      compare_field("right_drive", want.right_drv, got.right_drv);
      compare_field("left_fwd_duty", want.left_fwd, got.left_fwd);
      compare_field("left_rev_duty", want.left_rev, got.left_rev);
      compare_field("right_fwd_duty", want.right_fwd, got.right_fwd);
      compare_field("right_rev_duty", want.right_rev, got.right_rev);
      compare_field("ramped_speed_fwd", want.spd_fwd, got.spd_fwd);
      compare_field("ramped_speed_rot", want.spd_rot, got.spd_rot);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                    in_valid          = 1'b0;
  logic                    in_stall;
  logic                    cmd               = CMD_TICK;
  logic signed [7:0]       left_wheel_delta  = '0;
  logic signed [7:0]       right_wheel_delta = '0;
  logic signed [12:0]      wall_error        = '0;
  logic                    sensor_enable     = 1'b0;
  logic signed [CFG_W-1:0] goal_speed_fwd    = '0;
  logic signed [CFG_W-1:0] goal_speed_rot    = '0;
  logic                    out_valid;
  logic                    out_stall         = 1'b0;
  logic signed [DRV_W-1:0] left_drive, right_drive;
  logic [DUTY_W-1:0]       left_fwd_duty, left_rev_duty, right_fwd_duty, right_rev_duty;
  logic signed [CFG_W-1:0] ramped_speed_fwd, ramped_speed_rot;
  logic                    cfg_valid         = 1'b0;
  logic                    cfg_ready;
  logic [IDX_W-1:0]        cfg_index         = '0;
  logic [CFG_W-1:0]        cfg_data          = '0;

  drive_scoreboard         sb;
  int unsigned             send_gap_pct = 17;
  int unsigned             recv_gap_pct = 47;
  int unsigned             hold_token   = 0;
  int unsigned             hold_seen    = 0;
  int unsigned             hold_left    = 0;
  int unsigned             quiet_cycles = 0;
  logic signed [CFG_W-1:0] goal_fwd_now = '0;
  logic signed [CFG_W-1:0] goal_rot_now = '0;

  always #4 clk = ~clk;

  diff_drive_ramp_pd_controller #(
    .SENSOR_DIVISOR(SENS_DIV),
    .FRAC_BITS     (FRAC)
  ) u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .cmd              (cmd),
    .left_wheel_delta (left_wheel_delta),
    .right_wheel_delta(right_wheel_delta),
    .wall_error       (wall_error),
    .sensor_enable    (sensor_enable),
    .goal_speed_fwd   (goal_speed_fwd),
    .goal_speed_rot   (goal_speed_rot),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .left_drive       (left_drive),
    .right_drive      (right_drive),
    .left_fwd_duty    (left_fwd_duty),
    .left_rev_duty    (left_rev_duty),
    .right_fwd_duty   (right_fwd_duty),
    .right_rev_duty   (right_rev_duty),
    .ramped_speed_fwd (ramped_speed_fwd),
    .ramped_speed_rot (ramped_speed_rot),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // output stall: random, or a long hold-off counted here
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_gap_pct);
    end
  end

  // handshake monitor and watchdog
  always @(posedge clk) begin
    logic moved;
    moved = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        sb.note_tick({cmd, left_wheel_delta, right_wheel_delta, wall_error, sensor_enable,
                      goal_speed_fwd, goal_speed_rot});
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        sb.check_drive_word({left_drive, right_drive, left_fwd_duty, left_rev_duty,
                             right_fwd_duty, right_rev_duty, ramped_speed_fwd,
                             ramped_speed_rot});
        moved = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        sb.set_reg(cfg_index, cfg_data);
        moved = 1'b1;
      end
      if (moved) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic tick_t mk_tick(tick_cmd_e op, int dl, int dr, int wall, bit sens,
                                    int gf, int gr);
    tick_t t;
    t.op          = op;
    t.left_delta  = 8'(dl);
    t.right_delta = 8'(dr);
    t.wall_err    = 13'(wall);
    t.sensor_en   = sens;
    t.goal_fwd    = 16'(gf);
    t.goal_rot    = 16'(gr);
    return t;
  endfunction

  function automatic logic signed [CFG_W-1:0] pick_goal();
    case ($urandom_range(3))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(4095)) - 16'd2048;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [7:0] pick_delta();
    if ($urandom_range(1)) return 8'($urandom);
    return 8'($urandom_range(32)) - 8'd16;
  endfunction

  // goals hold for stretches so the ramps reach them, with occasional clears
  function automatic tick_t random_tick();
    tick_t t;
    if ($urandom_range(99) < 8) goal_fwd_now = pick_goal();
    if ($urandom_range(99) < 8) goal_rot_now = pick_goal();
    t.op          = ($urandom_range(99) < 4) ? CMD_CLEAR : CMD_TICK;
    t.left_delta  = pick_delta();
    t.right_delta = pick_delta();
    t.wall_err    = $urandom_range(1) ? 13'($urandom) : 13'($urandom_range(300)) - 13'd150;
    t.sensor_en   = 1'($urandom);
    t.goal_fwd    = goal_fwd_now;
    t.goal_rot    = goal_rot_now;
    return t;
  endfunction

  function automatic cfg_t random_cfg(bit full_range);
    cfg_t c;
    if (full_range) begin
      c = {$urandom, $urandom, $urandom, $urandom};
    end else begin
      c.accel_step_fwd = 16'($urandom_range(2000, 1));
      c.decel_step_fwd = 16'($urandom_range(2000, 1));
      c.accel_step_rot = 16'($urandom_range(2000, 1));
      c.decel_step_rot = 16'($urandom_range(2000, 1));
      c.prop_gain_fwd  = 16'($urandom_range(2048)) - 16'd1024;
      c.deriv_gain_fwd = 16'($urandom_range(2048)) - 16'd1024;
      c.prop_gain_rot  = 16'($urandom_range(2048)) - 16'd1024;
      c.deriv_gain_rot = 16'($urandom_range(2048)) - 16'd1024;
    end
    return c;
  endfunction

  // offer one input word, with random idle cycles ahead of it
  task automatic send_tick(input tick_t t);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    cmd               <= t.op;
    left_wheel_delta  <= t.left_delta;
    right_wheel_delta <= t.right_delta;
    wall_error        <= t.wall_err;
    sensor_enable     <= t.sensor_en;
    goal_speed_fwd    <= t.goal_fwd;
    goal_speed_rot    <= t.goal_rot;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic run_random(input int n);
    repeat (n) send_tick(random_tick());
  endtask

  // stop offering and wait until every drive word has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.drive_words_due.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_regs(input cfg_t c);
    put_reg(REG_ACCEL_FWD, c.accel_step_fwd);
    put_reg(REG_DECEL_FWD, c.decel_step_fwd);
    put_reg(REG_ACCEL_ROT, c.accel_step_rot);
    put_reg(REG_DECEL_ROT, c.decel_step_rot);
    put_reg(REG_KP_FWD, c.prop_gain_fwd);
    put_reg(REG_KD_FWD, c.deriv_gain_fwd);
    put_reg(REG_KP_ROT, c.prop_gain_rot);
    put_reg(REG_KD_ROT, c.deriv_gain_rot);
    cfg_valid <= 1'b0;
  endtask

  // main sequence
  initial begin
    cfg_t dflt;
    sb   = new();
    dflt = {RST_ACCEL_FWD, RST_DECEL_FWD, RST_ACCEL_ROT, RST_DECEL_ROT,
            RST_KP_FWD, RST_KD_FWD, RST_KP_ROT, RST_KD_ROT};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed words at reset gains
    send_tick(mk_tick(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
    send_tick(mk_tick(CMD_TICK, 0, 0, 0, 0, 0, 0));
    // both ramps overshoot and land on the goal, then hold there
    send_tick(mk_tick(CMD_TICK, 0, 0, 0, 0, 100, -200));
    send_tick(mk_tick(CMD_TICK, 0, 0, 0, 0, 100, -200));
    send_tick(mk_tick(CMD_TICK, 0, 0, 0, 0, -1, 1));
    // field extremes
    send_tick(mk_tick(CMD_TICK, 127, -128, 4095, 1, 32767, -32768));
    send_tick(mk_tick(CMD_TICK, -128, 127, -4096, 1, -32768, 32767));
    send_tick(mk_tick(CMD_TICK, -128, 127, -4096, 0, -32768, 32767));
    send_tick(mk_tick(CMD_TICK, 127, 127, 0, 0, 32767, 32767));
    send_tick(mk_tick(CMD_TICK, -128, -128, 0, 0, -32768, -32768));
    send_tick(mk_tick(CMD_TICK, 127, 127, 4095, 1, 32767, 32767));
    // wall term truncates toward zero
    send_tick(mk_tick(CMD_TICK, 0, 0, 49, 1, 0, 0));
    send_tick(mk_tick(CMD_TICK, 0, 0, -49, 1, 0, 0));
    send_tick(mk_tick(CMD_TICK, 3, 0, 151, 1, 0, 0));
    send_tick(mk_tick(CMD_TICK, 0, 3, -151, 1, 0, 0));
    send_tick(mk_tick(CMD_TICK, 0, 0, 50, 1, 0, 0));
    // clear in mid-profile ignores its other fields
    send_tick(mk_tick(CMD_CLEAR, 5, -5, 1000, 1, 32767, 32767));
    send_tick(mk_tick(CMD_TICK, 1, 2, 3, 1, 500, -500));
    send_tick(mk_tick(CMD_TICK, 0, 0, 0, 0, 500, -500));
    send_tick(mk_tick(CMD_TICK, -7, 9, 0, 0, 500, -500));
    run_random(60);

    // extreme step and gain settings, both ways round
    wait_drained();
    write_regs({16'd0, 16'hffff, 16'hffff, 16'd0, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000});
    run_random(130);
    wait_drained();
    write_regs({16'hffff, 16'd0, 16'd0, 16'hffff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff});
    send_gap_pct = 47;
    recv_gap_pct <= 17;
    run_random(120);

    // long output hold-off while words keep coming, then a full drain
    hold_token <= hold_token + 1;
    run_random(40);
    wait_drained();
    run_random(100);

    // moderate random settings with no idling
    wait_drained();
    write_regs(random_cfg(1'b0));
    send_gap_pct = 0;
    recv_gap_pct <= 0;
    run_random(150);
    hold_token <= hold_token + 1;
    run_random(40);

    wait_drained();
    write_regs(random_cfg(1'b1));
    run_random(150);

    // keep the rotational error sum growing at its fastest rate
    wait_drained();
    write_regs(dflt);
    send_tick(mk_tick(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
    repeat (SOAK_TICKS) begin
      send_tick(mk_tick(CMD_TICK, -120 - int'($urandom_range(8)),
                        120 + int'($urandom_range(7)),
                        -3800 - int'($urandom_range(296)), 1'b1,
                        int'($urandom), -32768));
    end

    wait_drained();
    repeat (END_SETTLE) @(posedge clk);
    if (sb.mismatches == 0 && sb.drive_words_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
